/* design/nss_pkg.sv */
// Package with shared constants, types and request codes of the substring search core.
package nss_pkg;

    localparam int MAX_LEN = 256;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = 9;
    localparam int BYTE_W  = 8;

    localparam logic [POS_W-1:0] MAX_LEN_POS = POS_W'(MAX_LEN);

    localparam logic [1:0] REQ_WRITE_TEXT    = 2'd0;
    localparam logic [1:0] REQ_WRITE_PATTERN = 2'd1;
    localparam logic [1:0] REQ_SEARCH        = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        write_index;
        logic [7:0]        data_byte;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  text_length;
        logic [POS_W-1:0]  pattern_length;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  match_pos;
    } t_out_item;

    typedef struct packed {
        logic              we_text;
        logic              we_pattern;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_text;
        logic [ADDR_W-1:0] raddr_pattern;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WAIT
    } t_state;

endpackage

/* design/nss_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module nss_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nss_ctrl.sv */
// Request decoder, comparison walk sequencer and output register of the search core.
module nss_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nss_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nss_pkg::t_out_item            o_out_data,
    output nss_pkg::t_mem_req             o_mem_req,
    input  logic [nss_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic [nss_pkg::BYTE_W-1:0]    i_pattern_byte
);

    nss_pkg::t_state                r_state, n_state;
    logic [nss_pkg::POS_W-1:0]      r_i, n_i;
    logic [nss_pkg::POS_W-1:0]      r_j, n_j;
    logic [nss_pkg::POS_W-1:0]      r_tlen, n_tlen;
    logic [nss_pkg::POS_W-1:0]      r_plen, n_plen;
    logic                           r_out_valid, n_out_valid;
    nss_pkg::t_out_item             r_out, n_out;

    logic [nss_pkg::POS_W-1:0]      sat_tlen;
    logic [nss_pkg::POS_W-1:0]      sat_plen;
    logic [nss_pkg::POS_W-1:0]      start_adj;
    logic [nss_pkg::POS_W-1:0]      step_i;
    logic [nss_pkg::POS_W-1:0]      step_j;
    logic                           wr_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_tlen <= n_tlen;
        r_plen <= n_plen;
        r_out  <= n_out;
    end

    always_comb begin
        sat_tlen = (i_in_data.text_length > nss_pkg::MAX_LEN_POS) ?
                   nss_pkg::MAX_LEN_POS : i_in_data.text_length;
        sat_plen = (i_in_data.pattern_length > nss_pkg::MAX_LEN_POS) ?
                   nss_pkg::MAX_LEN_POS : i_in_data.pattern_length;
        start_adj = (i_in_data.start_pos == '0) ?
                    nss_pkg::POS_W'(1) : i_in_data.start_pos;
        wr_in_range = nss_pkg::POS_W'(i_in_data.write_index) < nss_pkg::MAX_LEN_POS;

        if (i_text_byte == i_pattern_byte) begin
            step_i = r_i + nss_pkg::POS_W'(1);
            step_j = r_j + nss_pkg::POS_W'(1);
        end else begin
            step_i = r_i - r_j + nss_pkg::POS_W'(2);
            step_j = nss_pkg::POS_W'(1);
        end

        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_tlen      = r_tlen;
        n_plen      = r_plen;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        o_in_ready = (r_state == nss_pkg::ST_IDLE);

        o_mem_req.we_text       = 1'b0;
        o_mem_req.we_pattern    = 1'b0;
        o_mem_req.waddr         = i_in_data.write_index[nss_pkg::ADDR_W-1:0];
        o_mem_req.wdata         = i_in_data.data_byte;
        o_mem_req.raddr_text    = '0;
        o_mem_req.raddr_pattern = '0;

        unique case (r_state)
            nss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.req_type)
                        nss_pkg::REQ_WRITE_TEXT: begin
                            o_mem_req.we_text = wr_in_range;
                        end
                        nss_pkg::REQ_WRITE_PATTERN: begin
                            o_mem_req.we_pattern = wr_in_range;
                        end
                        nss_pkg::REQ_SEARCH: begin
                            n_tlen = sat_tlen;
                            n_plen = sat_plen;
                            n_i    = start_adj;
                            n_j    = nss_pkg::POS_W'(1);
                            o_mem_req.raddr_text =
                                nss_pkg::ADDR_W'(start_adj - nss_pkg::POS_W'(1));
                            if ((start_adj <= sat_tlen) && (sat_plen != '0)) begin
                                n_state = nss_pkg::ST_CMP;
                            end else begin
                                n_state = nss_pkg::ST_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            nss_pkg::ST_CMP: begin
                n_i = step_i;
                n_j = step_j;
                o_mem_req.raddr_text    = nss_pkg::ADDR_W'(step_i - nss_pkg::POS_W'(1));
                o_mem_req.raddr_pattern = nss_pkg::ADDR_W'(step_j - nss_pkg::POS_W'(1));
                if (!((step_i <= r_tlen) && (step_j <= r_plen))) begin
                    n_state = nss_pkg::ST_WAIT;
                end
            end
            nss_pkg::ST_WAIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out.found = (r_j > r_plen);
                    n_out.match_pos = (r_j > r_plen) ? (r_i - r_plen) : '0;
                    n_state = nss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nss_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_walk_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nss_pkg::ST_CMP) |-> (r_i <= r_tlen) && (r_j <= r_plen))
        else $error("Comparison walk left the text or pattern bounds.");

    a_pattern_behind_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nss_pkg::ST_CMP) |-> (r_j <= r_i) && (r_j != '0))
        else $error("Pattern index ran ahead of the text index.");

    a_found_has_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.match_pos != '0))
        else $error("Match reported at position zero.");

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != nss_pkg::ST_IDLE) |-> !(o_mem_req.we_text || o_mem_req.we_pattern))
        else $error("Store written during a search.");

    a_result_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == nss_pkg::ST_WAIT) && (!r_out_valid || i_out_ready))
        |=> (o_out_valid && (r_state == nss_pkg::ST_IDLE)))
        else $error("Finished search did not reach the output register.");

endmodule

/* design/naive_substring_search_core.sv */
// Top level of the brute-force substring search core: two byte stores and the sequencer.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries three kinds of
// transaction: a text byte write, a pattern byte write and a search request.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries one result
// transaction per search request: found flag and 1-based match position.
// Byte writes produce no result, so stores can be loaded at one transaction
// per cycle while no search runs.
// A search walks the stores one comparison per cycle, since both stores are
// synchronous RAMs read once per cycle at the addresses of the next compare.
// The input is not ready while a search runs; the result lands in an output
// register, so the next transaction is accepted while the result waits.
// If the receiver stalls and a second result finishes, the block holds it
// and stops taking input until the output register drains.
// Reset clears the sequencer and the output valid; store contents are kept
// and are undefined until written.
module naive_substring_search_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  nss_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output nss_pkg::t_out_item    o_out_data
);

    nss_pkg::t_mem_req              mem_req;
    logic [nss_pkg::BYTE_W-1:0]     text_byte;
    logic [nss_pkg::BYTE_W-1:0]     pattern_byte;

    nss_ram #(
        .WIDTH (nss_pkg::BYTE_W),
        .DEPTH (nss_pkg::MAX_LEN)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_text),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr_text),
        .o_rdata (text_byte)
    );

    nss_ram #(
        .WIDTH (nss_pkg::BYTE_W),
        .DEPTH (nss_pkg::MAX_LEN)
    ) u_pattern_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we_pattern),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr_pattern),
        .o_rdata (pattern_byte)
    );

    nss_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_data     (o_out_data),
        .o_mem_req      (mem_req),
        .i_text_byte    (text_byte),
        .i_pattern_byte (pattern_byte)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the substring search core with a byte-store mirror and match predictor.
module tb_top;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 50;
    localparam int PHASE_ITEMS    = 140;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    nss_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    nss_pkg::t_out_item out_data;

    logic [nss_pkg::BYTE_W-1:0] text_mem    [nss_pkg::MAX_LEN];
    logic [nss_pkg::BYTE_W-1:0] pattern_mem [nss_pkg::MAX_LEN];
    nss_pkg::t_out_item         pending_results [$];

    int unsigned mismatches     = 0;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_left      = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_request   = 1'b0;

    always #5 clk = ~clk;

    naive_substring_search_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic nss_pkg::t_out_item find_first_match(input nss_pkg::t_in_item req);
        int unsigned        first;
        int unsigned        tlen;
        int unsigned        plen;
        int unsigned        pos;
        int unsigned        k;
        nss_pkg::t_out_item res;
        first = req.start_pos;
        if (first == 0) begin
            first = 1;
        end
        tlen = (req.text_length > nss_pkg::MAX_LEN) ? nss_pkg::MAX_LEN : req.text_length;
        plen = (req.pattern_length > nss_pkg::MAX_LEN) ? nss_pkg::MAX_LEN : req.pattern_length;
        pos  = first;
        k    = 1;
        while (pos <= tlen && k <= plen) begin
            if (text_mem[pos - 1] == pattern_mem[k - 1]) begin
                pos++;
                k++;
            end else begin
                pos = pos - k + 2;
                k   = 1;
            end
        end
        res.found     = (k > plen);
        res.match_pos = res.found ? nss_pkg::POS_W'(pos - plen) : '0;
        return res;
    endfunction

    function automatic nss_pkg::t_in_item random_fields();
        nss_pkg::t_in_item it;
        it.req_type       = 2'($urandom);
        it.write_index    = 8'($urandom);
        it.data_byte      = 8'($urandom);
        it.start_pos      = nss_pkg::POS_W'($urandom);
        it.text_length    = nss_pkg::POS_W'($urandom);
        it.pattern_length = nss_pkg::POS_W'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'h61 + 8'($urandom_range(3));
    endfunction

    task automatic mirror_transaction(input nss_pkg::t_in_item item);
        case (item.req_type)
            nss_pkg::REQ_WRITE_TEXT: begin
                text_mem[item.write_index] = item.data_byte;
            end
            nss_pkg::REQ_WRITE_PATTERN: begin
                pattern_mem[item.write_index] = item.data_byte;
            end
            nss_pkg::REQ_SEARCH: begin
                pending_results.push_back(find_first_match(item));
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input nss_pkg::t_in_item item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        mirror_transaction(item);
        if (item.req_type != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic write_byte(input logic [1:0] kind, input int unsigned idx,
                              input logic [7:0] data);
        nss_pkg::t_in_item it;
        it             = random_fields();
        it.req_type    = kind;
        it.write_index = idx[7:0];
        it.data_byte   = data;
        send_item(it);
    endtask

    task automatic search_text(input int unsigned start, input int unsigned tlen,
                               input int unsigned plen);
        nss_pkg::t_in_item it;
        it                = random_fields();
        it.req_type       = nss_pkg::REQ_SEARCH;
        it.start_pos      = nss_pkg::POS_W'(start);
        it.text_length    = nss_pkg::POS_W'(tlen);
        it.pattern_length = nss_pkg::POS_W'(plen);
        send_item(it);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic test_store_fill();
        send_idle_pct = 0;
        for (int k = 0; k < nss_pkg::MAX_LEN; k++) begin
            write_byte(nss_pkg::REQ_WRITE_TEXT, k, random_letter());
            write_byte(nss_pkg::REQ_WRITE_PATTERN, k, random_letter());
        end
    endtask

    task automatic test_directed();
        nss_pkg::t_in_item it;
        write_byte(nss_pkg::REQ_WRITE_TEXT, 0, 8'h00);
        write_byte(nss_pkg::REQ_WRITE_TEXT, 255, 8'hFF);
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 255, 8'h00);
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 0, 8'h00);
        search_text(1, 1, 1);
        search_text(0, 0, 0);
        search_text(511, 511, 0);
        search_text(10, 5, 1);
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 0, 8'hFF);
        search_text(200, 511, 1);
        search_text(256, 256, 1);
        search_text(1, 256, 511);
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 0, 8'h7F);
        search_text(1, 256, 1);
        // A partial match after which the next attempt restarts one past the previous start.
        write_byte(nss_pkg::REQ_WRITE_TEXT, 1, "a");
        write_byte(nss_pkg::REQ_WRITE_TEXT, 2, "a");
        write_byte(nss_pkg::REQ_WRITE_TEXT, 3, "b");
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 0, "a");
        write_byte(nss_pkg::REQ_WRITE_PATTERN, 1, "b");
        search_text(2, 4, 2);
        it          = random_fields();
        it.req_type = REQ_UNUSED;
        send_item(it);
        wait_results_drained();
    endtask

    task automatic run_search_sequence();
        int unsigned tlen;
        int unsigned plen;
        int unsigned tlen_eff;
        int unsigned start;
        int unsigned off;
        logic [7:0]  ch;
        tlen     = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(40, 1);
        plen     = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(6);
        tlen_eff = (tlen > nss_pkg::MAX_LEN) ? nss_pkg::MAX_LEN : tlen;
        start    = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(tlen_eff);
        repeat ($urandom_range(3)) begin
            write_byte(nss_pkg::REQ_WRITE_TEXT, $urandom_range(255), random_letter());
        end
        if (plen >= 1 && plen <= 8) begin
            if (plen <= tlen_eff && $urandom_range(1) == 1) begin
                off = $urandom_range(tlen_eff - plen);
                for (int k = 0; k < plen; k++) begin
                    ch = random_letter();
                    write_byte(nss_pkg::REQ_WRITE_PATTERN, k, ch);
                    write_byte(nss_pkg::REQ_WRITE_TEXT, off + k, ch);
                end
            end else if ($urandom_range(1) == 1) begin
                for (int k = 0; k < plen; k++) begin
                    write_byte(nss_pkg::REQ_WRITE_PATTERN, k, random_letter());
                end
            end
        end
        search_text(start, tlen, plen);
    endtask

    task automatic test_random(input int unsigned count, input int sender_pct,
                               input int receiver_pct);
        int unsigned target;
        send_idle_pct  = sender_pct;
        recv_stall_pct <= receiver_pct;
        target         = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(99) < 20) begin
                send_item(random_fields());
            end else begin
                run_search_sequence();
            end
        end
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_request  <= 1'b1;
        repeat (10) begin
            search_text(1, $urandom_range(20, 4), $urandom_range(3));
        end
        wait_results_drained();
    endtask

    always @(negedge clk) begin
        if (hold_request) begin
            hold_request <= 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        nss_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transaction with none expected: found=%0d match_pos=%0d",
                         $time, out_data.found, out_data.match_pos);
            end else begin
                want = pending_results.pop_front();
                if (want.found !== out_data.found || want.match_pos !== out_data.match_pos) begin
                    mismatches++;
                    $display("%0t: expected found=%0d match_pos=%0d, actual found=%0d match_pos=%0d",
                             $time, want.found, want.match_pos,
                             out_data.found, out_data.match_pos);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_store_fill();
        test_directed();
        test_random(PHASE_ITEMS, 0, 0);
        test_random(PHASE_ITEMS, 69, 0);
        test_backpressure();
        test_random(PHASE_ITEMS, 0, 69);
        test_random(PHASE_ITEMS, 14, 14);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
design/nss_pkg.sv
design/nss_ram.sv
design/nss_ctrl.sv
design/naive_substring_search_core.sv
tb/sv/tb_top.sv
